// ===== hw/rtl/i2cbm_pkg.sv =====
// Shared types, command codes and pin-phase decode for the bit-level I2C master.
// No dependencies; used by i2cbm_core and i2c_bit_level_master.
`timescale 1ns / 1ps

package i2cbm_pkg;

  // Commands on the input channel; tick also marks the idle command slot
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_RDACK = 3'd4,
    OP_RDNAK = 3'd5
  } op_t;

  localparam op_t CMD_IDLE = OP_TICK;

  localparam int unsigned TDATA_IN_W  = 16;
  localparam int unsigned TUSER_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 16;

  // One pin update: hit says whether a pin changes at all
  typedef struct packed {
    logic hit;
    logic is_sda;
    logic lvl;
  } pin_set_t;

  // One result item
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

  function automatic logic [4:0] phase_total(op_t cmd);
    case (cmd)
      OP_START: return 5'd4;
      OP_STOP:  return 5'd4;
      OP_WRITE: return 5'd27;
      OP_RDACK: return 5'd21;
      OP_RDNAK: return 5'd19;
      default:  return 5'd0;
    endcase
  endfunction

  // Read commands sample SDA at the end of every SCL-high phase of the eight data bits
  function automatic logic is_sample_phase(op_t cmd, logic [4:0] idx);
    return (cmd == OP_RDACK || cmd == OP_RDNAK) &&
           (idx >= 5'd1) && (idx <= 5'd16) && idx[0];
  endfunction

  // Pin set for phase idx of cmd; sb is the byte being written
  function automatic pin_set_t apply_phase(op_t cmd, logic [4:0] idx, logic [7:0] sb);
    pin_set_t   ps;
    logic [9:0] prod;
    logic [4:0] b;
    logic [4:0] r;
    ps   = '{hit: 1'b1, is_sda: 1'b0, lvl: 1'b1};
    // idx / 3 for idx below 24 as a reciprocal multiply
    prod = {5'd0, idx} * 10'd11;
    b    = prod[9:5];
    r    = idx - 5'(b * 5'd3);
    case (cmd)
      OP_START: begin
        case (idx)
          5'd0:    ps = '{hit: 1'b1, is_sda: 1'b0, lvl: 1'b1};
          5'd1:    ps = '{hit: 1'b1, is_sda: 1'b1, lvl: 1'b1};
          5'd2:    ps = '{hit: 1'b1, is_sda: 1'b1, lvl: 1'b0};
          5'd3:    ps = '{hit: 1'b1, is_sda: 1'b0, lvl: 1'b0};
          default: ps.hit = 1'b0;
        endcase
      end
      OP_STOP: begin
        case (idx)
          5'd0:    ps = '{hit: 1'b1, is_sda: 1'b0, lvl: 1'b0};
          5'd1:    ps = '{hit: 1'b1, is_sda: 1'b1, lvl: 1'b0};
          5'd2:    ps = '{hit: 1'b1, is_sda: 1'b0, lvl: 1'b1};
          5'd3:    ps = '{hit: 1'b1, is_sda: 1'b1, lvl: 1'b1};
          default: ps.hit = 1'b0;
        endcase
      end
      OP_WRITE: begin
        if (idx < 5'd24) begin
          if (r == 5'd0) begin
            ps.is_sda = 1'b1;
            ps.lvl    = sb[3'd7 - b[2:0]];
          end else begin
            ps.lvl = (r == 5'd1);
          end
        end else if (idx == 5'd24) begin
          ps.is_sda = 1'b1;
        end else begin
          ps.lvl = (idx == 5'd25);
        end
      end
      OP_RDACK, OP_RDNAK: begin
        if (idx == 5'd0) begin
          ps.is_sda = 1'b1;
        end else if (idx <= 5'd16) begin
          ps.lvl = idx[0];
        end else if (cmd == OP_RDACK) begin
          case (idx)
            5'd17:   ps = '{hit: 1'b1, is_sda: 1'b1, lvl: 1'b0};
            5'd18:   ps = '{hit: 1'b1, is_sda: 1'b0, lvl: 1'b1};
            5'd19:   ps = '{hit: 1'b1, is_sda: 1'b0, lvl: 1'b0};
            default: ps = '{hit: 1'b1, is_sda: 1'b1, lvl: 1'b1};
          endcase
        end else begin
          ps.lvl = (idx == 5'd17);
        end
      end
      default: ps.hit = 1'b0;
    endcase
    return ps;
  endfunction

endpackage

// ===== hw/rtl/i2c_bit_level_master.sv =====
// Bit-level I2C master: an accepted input item is held in the input register, then passes
// through the sequencer into the result register, from which it leaves as a result item.
// Throughput is one item per cycle while out_tready drains results; the two registers
// each hold one item, so the input register can still take one item while a result waits.
// Reset (rst_n low, synchronous) empties both registers, releases SCL and SDA,
// clears the sequencer to idle and sets phase_ticks to one. Depends on i2cbm_pkg and i2cbm_core.
`timescale 1ns / 1ps

module i2c_bit_level_master (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: phase_ticks
  input  logic                              cfg_wr_en,
  input  logic [7:0]                        cfg_wr_data,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cbm_pkg::TDATA_IN_W-1:0]  in_tdata,   // [7:0] data, [8] sda_in, rest zero
  input  logic [i2cbm_pkg::TUSER_IN_W-1:0]  in_tuser,   // [2:0] op, rest zero
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cbm_pkg::TDATA_OUT_W-1:0] out_tdata   // [0] scl, [1] sda, [2] busy_res,
                                                        // [3] done_res, [11:4] read_data,
                                                        // [12] rejected, rest zero
);
  import i2cbm_pkg::*;

  // Bus speed register; the user must write it only while the block is idle (not enforced here)
  logic [7:0] phase_ticks_r;

  // Input register stage
  logic       s1_valid_r;
  logic [2:0] s1_op_r;
  logic [7:0] s1_data_r;
  logic       s1_sdi_r;

  // Result register stage
  logic       out_valid_r;
  res_t       out_res_r;

  logic       s1_adv;
  logic       in_acc;
  res_t       step_res;

  // Move the held item through the sequencer when the result slot is free
  // or is being emptied in this same cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= 8'd1;
    end else if (cfg_wr_en) begin
      phase_ticks_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_tuser[2:0];
      s1_data_r <= in_tdata[7:0];
      s1_sdi_r  <= in_tdata[8];
    end
  end

  // Sequencer state advances exactly once per item
  i2cbm_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_adv),
    .op          (s1_op_r),
    .data        (s1_data_r),
    .sdi         (s1_sdi_r),
    .phase_ticks (phase_ticks_r),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_res_r.rejected, out_res_r.read_data, out_res_r.done,
                       out_res_r.busy, out_res_r.sda, out_res_r.scl};

`ifndef ASSERT_OFF
  // A rejected command never finishes a command in the same item
  a_rej_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_res_r.rejected && out_res_r.done))
    else $error("rejected and done in one result item");

  // Finishing a command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.done |-> !out_res_r.busy)
    else $error("done item still reports busy");

  // A command is only rejected while another one keeps the sequencer busy
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.rejected |-> out_res_r.busy)
    else $error("rejected item while idle");

  // The input side stalls only when the held item cannot move on
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");
`endif

endmodule

// ===== hw/rtl/i2cbm_core.sv =====
// Command sequencer state and per-item step logic of the bit-level I2C master.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps

module i2cbm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [2:0]        op,
  input  logic [7:0]        data,
  input  logic              sdi,
  input  logic [7:0]        phase_ticks,
  output i2cbm_pkg::res_t   res
);
  import i2cbm_pkg::*;

  op_t        cmd_r, cmd_nxt;
  logic [4:0] phase_r, phase_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic [7:0] last_r, last_nxt;

  logic       done;
  logic       rej;
  logic       is_cmd;
  logic [7:0] limit;
  logic [7:0] tick_inc;
  logic [4:0] phase_inc;
  pin_set_t   ps;

  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    last_nxt  = last_r;
    done      = 1'b0;
    rej       = 1'b0;
    ps        = '0;
    is_cmd    = (op >= 3'(OP_START)) && (op <= 3'(OP_RDNAK));
    limit     = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    tick_inc  = tick_r + 8'd1;
    phase_inc = phase_r + 5'd1;

    if (is_cmd) begin
      if (cmd_r != CMD_IDLE) begin
        rej = 1'b1;
      end else begin
        cmd_nxt   = op_t'(op);
        phase_nxt = 5'd0;
        tick_nxt  = 8'd0;
        shift_nxt = (op_t'(op) == OP_WRITE) ? data : 8'd0;
        ps        = apply_phase(op_t'(op), 5'd0, shift_nxt);
      end
    end else if (cmd_r != CMD_IDLE) begin
      if (tick_inc >= limit) begin
        tick_nxt = 8'd0;
        if (is_sample_phase(cmd_r, phase_r)) begin
          shift_nxt = {shift_r[6:0], sdi};
        end
        if (phase_inc >= phase_total(cmd_r)) begin
          if (cmd_r == OP_RDACK || cmd_r == OP_RDNAK) begin
            last_nxt = shift_nxt;
          end
          done      = 1'b1;
          cmd_nxt   = CMD_IDLE;
          phase_nxt = 5'd0;
        end else begin
          phase_nxt = phase_inc;
          ps        = apply_phase(cmd_r, phase_inc, shift_nxt);
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end

    if (ps.hit) begin
      if (ps.is_sda) begin
        sda_nxt = ps.lvl;
      end else begin
        scl_nxt = ps.lvl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_IDLE;
      phase_r <= 5'd0;
      tick_r  <= 8'd0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      last_r  <= 8'd0;
    end else if (step_en) begin
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      last_r  <= last_nxt;
    end
  end

  assign res = '{scl: scl_nxt, sda: sda_nxt, busy: (cmd_nxt != CMD_IDLE), done: done,
                 read_data: last_nxt, rejected: rej};

endmodule
